// File: design/etmd_pkg.sv
// etmd_pkg: shared types, constants and register codes for the edge-timed
// Manchester decoder. No dependencies; every other design file imports it.

package etmd_pkg;

    // fixed field widths
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 11;
    localparam int TOL_W   = 10;
    localparam int END_W   = 12;

    // recorded edge cap, header bits included
    localparam logic [COUNT_W-1:0] MAX_BITS    = 11'd1024;
    localparam logic [COUNT_W-1:0] HEADER_BITS = 11'd2;

    // percent scale for the cross-multiplied deviation test
    localparam logic [6:0] PCT_SCALE = 7'd100;

    // widths of the deviation products
    localparam int LHS_W = TIME_W + 7;
    localparam int RHS_W = TIME_W + END_W;

    // register reset values
    localparam logic [TOL_W-1:0] TOL_RESET = 10'd25;
    localparam logic [END_W-1:0] END_RESET = 12'd300;

    // APB address and register codes (paddr[2] selects the register)
    localparam int   PADDR_W      = 3;
    localparam int   PDATA_W      = 32;
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_END       = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_END_OK    = 2'd1,
        KIND_END_SHORT = 2'd2
    } t_kind;

    // configuration seen by the decoder core
    typedef struct packed {
        logic [TOL_W-1:0] tol_pct;
        logic [END_W-1:0] end_pct;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_kind              kind;
        logic               bit_value;
        logic [COUNT_W-1:0] bits_recorded;
        logic               overflowed;
    } t_result;

endpackage

// File: design/etmd_edge_if.sv
// etmd_edge_if: valid/ready channel carrying one timestamped line edge.
// Depends on etmd_pkg.

interface etmd_edge_if import etmd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              edge_level;
    logic [TIME_W-1:0] edge_time;

    modport source (output valid, edge_level, edge_time, input ready);
    modport sink   (input valid, edge_level, edge_time, output ready);
endinterface

// File: design/etmd_result_if.sv
// etmd_result_if: valid/ready channel carrying one decoder result.
// Depends on etmd_pkg.

interface etmd_result_if import etmd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic               bit_value;
    logic [COUNT_W-1:0] bits_recorded;
    logic               overflowed;

    modport source (output valid, result_kind, bit_value, bits_recorded, overflowed,
                    input ready);
    modport sink   (input valid, result_kind, bit_value, bits_recorded, overflowed,
                    output ready);
endinterface

// File: design/etmd_apb_regs.sv
// etmd_apb_regs: APB-style register file holding tolerance and end percent.
// Depends on etmd_pkg.

module etmd_apb_regs import etmd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [TOL_W-1:0] r_tol_pct;
    logic [END_W-1:0] r_end_pct;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, data masked to register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_pct <= TOL_RESET;
            r_end_pct <= END_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TOLERANCE: r_tol_pct <= pwdata[TOL_W-1:0];
                REG_END:       r_end_pct <= pwdata[END_W-1:0];
                default:       ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            REG_TOLERANCE: prdata = PDATA_W'(r_tol_pct);
            REG_END:       prdata = PDATA_W'(r_end_pct);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.tol_pct = r_tol_pct;
    assign o_cfg.end_pct = r_end_pct;

endmodule

// File: design/etmd_core.sv
// etmd_core: decoder state (reference periods, timing origin, bit count) and
// the single-pass edge classification. Depends on etmd_pkg.

module etmd_core import etmd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_step,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_time,
    output logic              o_has_result,
    output t_result           o_result
);

    logic [TIME_W-1:0]  r_last_time, n_last_time;
    logic [TIME_W-1:0]  r_rise_period, n_rise_period;
    logic [TIME_W-1:0]  r_fall_period, n_fall_period;
    logic               r_await_fall, n_await_fall;
    logic               r_await_rise_per, n_await_rise_per;
    logic               r_not_armed, n_not_armed;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_ovf, n_ovf;

    logic               learn_rise, learn_fall;
    logic [TIME_W-1:0]  span, rise_l, fall_l, last_l, ref_per, dt, dev;
    logic               await_fall_l, not_armed_l, skip;
    logic [LHS_W-1:0]   lhs;
    logic [RHS_W-1:0]   end_rhs, tol_rhs;
    logic               is_end, is_mid, is_acc, at_cap;
    logic [COUNT_W-1:0] count_inc;

    // learning of reference periods and timing origin
    assign span       = i_time - r_last_time;
    assign learn_rise = (r_rise_period == '0) && !r_await_fall && !i_level;
    assign learn_fall = r_await_rise_per && i_level && !r_await_fall;

    assign rise_l       = learn_rise ? span : r_rise_period;
    assign fall_l       = learn_fall ? span : r_fall_period;
    assign not_armed_l  = r_not_armed && !learn_rise && !learn_fall;
    assign await_fall_l = r_await_fall && i_level;
    assign last_l       = (r_await_fall && !i_level) ? i_time : r_last_time;

    // interval deviation against the reference of this direction
    assign ref_per = i_level ? fall_l : rise_l;
    assign skip    = await_fall_l || (ref_per == '0) || not_armed_l;
    assign dt      = i_time - last_l;
    assign dev     = (ref_per > dt) ? (ref_per - dt) : (dt - ref_per);
    assign lhs     = LHS_W'(dev) * LHS_W'(PCT_SCALE);
    assign end_rhs = RHS_W'(i_cfg.end_pct) * RHS_W'(ref_per);
    assign tol_rhs = RHS_W'(i_cfg.tol_pct) * RHS_W'(ref_per);

    assign is_end = !skip && (RHS_W'(lhs) > end_rhs);
    assign is_mid = !skip && !is_end && (RHS_W'(lhs) > tol_rhs);
    assign is_acc = !skip && !is_end && !is_mid;

    assign at_cap    = r_count >= MAX_BITS;
    assign count_inc = r_count + COUNT_W'(1);

    // next state
    always_comb begin
        n_last_time      = last_l;
        n_rise_period    = rise_l;
        n_fall_period    = fall_l;
        n_await_fall     = await_fall_l;
        n_await_rise_per = r_await_rise_per && !learn_fall;
        n_not_armed      = not_armed_l;
        n_count          = r_count;
        n_ovf            = r_ovf;
        priority if (is_end) begin
            // end of message rearms everything but the registers
            n_last_time      = '0;
            n_rise_period    = '0;
            n_fall_period    = '0;
            n_await_fall     = 1'b1;
            n_await_rise_per = 1'b1;
            n_not_armed      = 1'b1;
            n_count          = '0;
            n_ovf            = 1'b0;
        end else if (is_acc) begin
            n_last_time = i_time;
            if (at_cap) begin
                n_ovf = 1'b1;
            end else begin
                n_count = count_inc;
            end
        end
    end

    // result for this edge
    always_comb begin
        o_has_result           = 1'b0;
        o_result.kind          = KIND_DATA;
        o_result.bit_value     = 1'b0;
        o_result.bits_recorded = r_count;
        o_result.overflowed    = r_ovf;
        priority if (is_end) begin
            o_has_result  = 1'b1;
            o_result.kind = (r_count < HEADER_BITS) ? KIND_END_SHORT : KIND_END_OK;
        end else if (is_acc && !at_cap && (count_inc > HEADER_BITS)) begin
            o_has_result           = 1'b1;
            o_result.bit_value     = !i_level;
            o_result.bits_recorded = count_inc;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time      <= '0;
            r_rise_period    <= '0;
            r_fall_period    <= '0;
            r_await_fall     <= 1'b1;
            r_await_rise_per <= 1'b1;
            r_not_armed      <= 1'b1;
            r_count          <= '0;
            r_ovf            <= 1'b0;
        end else if (i_step) begin
            r_last_time      <= n_last_time;
            r_rise_period    <= n_rise_period;
            r_fall_period    <= n_fall_period;
            r_await_fall     <= n_await_fall;
            r_await_rise_per <= n_await_rise_per;
            r_not_armed      <= n_not_armed;
            r_count          <= n_count;
            r_ovf            <= n_ovf;
        end
    end

endmodule

// File: design/edge_timed_manchester_decoder_unit.sv
// edge_timed_manchester_decoder_unit: top level with input register, decoder
// core and output register. Depends on etmd_pkg, etmd_edge_if, etmd_result_if,
// etmd_apb_regs and etmd_core.
//
//   channel    direction  carries                                     handshake
//   i_edge     in         edge_level, edge_time                       valid/ready
//   o_result   out        result_kind, bit_value, bits_recorded,      valid/ready
//                         overflowed
//   APB        in/out     tolerance_percent (0x0), end_percent (0x4)  psel/penable
//
// One edge per cycle sustained while the output is not stalled; a result is
// registered twice: input register at the edge transfer, then output register.
// The core's subtract, three multiplies and compare set the cycle path.
// Reset is synchronous, active low; registers return to 25 and 300 percent.
// A stalled output holds its result; an edge held in the input register then
// waits there and blocks the input until the output is taken.

module edge_timed_manchester_decoder_unit import etmd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    etmd_edge_if.sink          i_edge,
    etmd_result_if.source      o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg              cfg;
    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    t_result           r_out;
    logic              proc;
    logic              has_result;
    t_result           result;

    etmd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the held edge is processed when the output register can take a result
    assign proc         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_edge.ready = !r_in_valid || proc;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_edge.ready) begin
            r_in_valid <= i_edge.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_edge.valid && i_edge.ready) begin
            r_in_level <= i_edge.edge_level;
            r_in_time  <= i_edge.edge_time;
        end
    end

    etmd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_step       (proc),
        .i_level      (r_in_level),
        .i_time       (r_in_time),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && has_result) begin
            r_out <= result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.result_kind   = r_out.kind;
    assign o_result.bit_value     = r_out.bit_value;
    assign o_result.bits_recorded = r_out.bits_recorded;
    assign o_result.overflowed    = r_out.overflowed;

endmodule
